// File: sv/ssag_pkg.sv
// Package for the six-speaker panner: types, constants and the gain program.
`default_nettype none
package ssag_pkg;

  localparam int QBITS    = 30;
  localparam int QW       = 32;
  localparam int RF_AW    = 5;
  localparam int RF_DEPTH = 1 << RF_AW;
  localparam int PC_W     = 7;
  localparam int PROG_LEN = 77;
  localparam int SINE_OPS = 56;
  localparam int N_CH     = 6;
  localparam logic [QW-1:0] Q_ONE = QW'(1) << QBITS;

  // Configuration register indexes.
  localparam logic REG_ANGLE_X = 1'b0;
  localparam logic REG_ANGLE_Y = 1'b1;

  // Scratch register file of the gain engine.
  localparam logic [RF_AW-1:0] R_T   = 5'd0;
  localparam logic [RF_AW-1:0] R_T2  = 5'd1;
  localparam logic [RF_AW-1:0] R_ACC = 5'd2;
  localparam logic [RF_AW-1:0] R_S0  = 5'd3;
  localparam logic [RF_AW-1:0] R_S1  = 5'd4;
  localparam logic [RF_AW-1:0] R_S2  = 5'd5;
  localparam logic [RF_AW-1:0] R_S3  = 5'd6;
  localparam logic [RF_AW-1:0] R_S4  = 5'd7;
  localparam logic [RF_AW-1:0] R_S5  = 5'd8;
  localparam logic [RF_AW-1:0] R_S6  = 5'd9;
  localparam logic [RF_AW-1:0] R_SX2 = 5'd10;
  localparam logic [RF_AW-1:0] R_CX2 = 5'd11;
  localparam logic [RF_AW-1:0] R_SY2 = 5'd12;
  localparam logic [RF_AW-1:0] R_P2  = 5'd13;
  localparam logic [RF_AW-1:0] R_P4  = 5'd14;
  localparam logic [RF_AW-1:0] R_P8  = 5'd15;
  localparam logic [RF_AW-1:0] R_A   = 5'd16;
  localparam logic [RF_AW-1:0] R_B   = 5'd17;
  localparam logic [RF_AW-1:0] R_C   = 5'd18;

  // Phase codes for the sine loads.
  localparam logic [2:0] PH_SX = 3'd0;
  localparam logic [2:0] PH_CX = 3'd1;
  localparam logic [2:0] PH_SY = 3'd2;
  localparam logic [2:0] PH_CY = 3'd3;
  localparam logic [2:0] PH_A  = 3'd4;
  localparam logic [2:0] PH_B  = 3'd5;
  localparam logic [2:0] PH_C  = 3'd6;

  typedef enum logic [2:0] {
    OP_LOADT,
    OP_PLAIN,
    OP_SUBK,
    OP_FINAL,
    OP_GAIN
  } op_kind_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RD,
    ENG_MUL,
    ENG_WB
  } eng_state_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [RF_AW-1:0] ra;
    logic [RF_AW-1:0] rb;
    logic             b_const;
    logic [2:0]       k;
    logic [RF_AW-1:0] dst;
  } op_t;

  // Quarter-wave sine polynomial coefficients in Q30.
  function automatic logic [QW-1:0] poly(input logic [2:0] k);
    logic [QW-1:0] c;
    case (k)
      3'd0:    c = 32'd1686629713;
      3'd1:    c = 32'd693598668;
      3'd2:    c = 32'd85569306;
      3'd3:    c = 32'd5026994;
      3'd4:    c = 32'd172272;
      3'd5:    c = 32'd3864;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic op_t mk(input op_kind_e kind, input logic [RF_AW-1:0] ra,
                             input logic [RF_AW-1:0] rb, input logic [RF_AW-1:0] dst);
    op_t o;
    o.kind    = kind;
    o.ra      = ra;
    o.rb      = rb;
    o.b_const = 1'b0;
    o.k       = 3'd0;
    o.dst     = dst;
    return o;
  endfunction

  // Each sine takes eight steps; the products and gains follow.
  function automatic op_t prog(input logic [PC_W-1:0] pc);
    op_t             o;
    logic [2:0]      s;
    logic [2:0]      u;
    logic [PC_W-1:0] idx;
    s   = pc[5:3];
    u   = pc[2:0];
    idx = pc - PC_W'(SINE_OPS);
    o   = mk(OP_PLAIN, R_T2, R_ACC, R_ACC);
    if (pc < PC_W'(SINE_OPS)) begin
      case (u)
        3'd0: o = mk(OP_LOADT, {2'b00, s}, R_T, R_T);
        3'd1: o = mk(OP_PLAIN, R_T, R_T, R_T2);
        3'd2: begin
          o         = mk(OP_SUBK, R_T2, R_T2, R_ACC);
          o.b_const = 1'b1;
          o.k       = 3'd4;
        end
        3'd7: o = mk(OP_FINAL, R_T, R_ACC, R_S0 + RF_AW'(s));
        default: begin
          o   = mk(OP_SUBK, R_T2, R_ACC, R_ACC);
          o.k = 3'd6 - u;
        end
      endcase
    end else begin
      case (idx)
        7'd0:  o = mk(OP_PLAIN, R_S0, R_S0, R_SX2);
        7'd1:  o = mk(OP_PLAIN, R_S1, R_S1, R_CX2);
        7'd2:  o = mk(OP_PLAIN, R_S2, R_S2, R_SY2);
        7'd3:  o = mk(OP_PLAIN, R_S4, R_S4, R_P2);
        7'd4:  o = mk(OP_PLAIN, R_P2, R_P2, R_P4);
        7'd5:  o = mk(OP_PLAIN, R_P4, R_P4, R_P8);
        7'd6:  o = mk(OP_PLAIN, R_P8, R_P2, R_A);
        7'd7:  o = mk(OP_PLAIN, R_S5, R_S5, R_P2);
        7'd8:  o = mk(OP_PLAIN, R_P2, R_P2, R_P4);
        7'd9:  o = mk(OP_PLAIN, R_P4, R_P4, R_P8);
        7'd10: o = mk(OP_PLAIN, R_P8, R_P2, R_B);
        7'd11: o = mk(OP_PLAIN, R_S6, R_S6, R_P2);
        7'd12: o = mk(OP_PLAIN, R_P2, R_P2, R_P4);
        7'd13: o = mk(OP_PLAIN, R_P4, R_P4, R_P8);
        7'd14: o = mk(OP_PLAIN, R_P8, R_P2, R_C);
        7'd15: o = mk(OP_GAIN, R_SX2, R_SY2, 5'd0);
        7'd16: o = mk(OP_GAIN, R_CX2, R_SY2, 5'd1);
        7'd17: o = mk(OP_GAIN, R_A, R_S3, 5'd2);
        7'd18: o = mk(OP_GAIN, R_A, R_S2, 5'd3);
        7'd19: o = mk(OP_GAIN, R_B, R_S0, 5'd4);
        7'd20: o = mk(OP_GAIN, R_C, R_S1, 5'd5);
        default: o = mk(OP_PLAIN, R_T, R_T, R_T);
      endcase
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// File: sv/ssag_if.sv
// Item channel interfaces for the panner's input and output.
`default_nettype none
interface ssag_in_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] in_ch3;
  logic signed [W-1:0] in_ch4;
  logic signed [W-1:0] in_ch5;
  logic signed [W-1:0] in_ch6;
  logic signed [W-1:0] in_ch7;
  logic signed [W-1:0] in_ch8;
  modport source (output valid, in_ch3, in_ch4, in_ch5, in_ch6, in_ch7, in_ch8,
                  input ready);
  modport sink (input valid, in_ch3, in_ch4, in_ch5, in_ch6, in_ch7, in_ch8,
                output ready);
endinterface

interface ssag_out_if #(parameter int W = 24);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_ch3;
  logic signed [W-1:0] out_ch4;
  logic signed [W-1:0] out_ch5;
  logic signed [W-1:0] out_ch6;
  logic signed [W-1:0] out_ch7;
  logic signed [W-1:0] out_ch8;
  modport source (output valid, out_ch3, out_ch4, out_ch5, out_ch6, out_ch7, out_ch8,
                  input ready);
  modport sink (input valid, out_ch3, out_ch4, out_ch5, out_ch6, out_ch7, out_ch8,
                output ready);
endinterface
`default_nettype wire

// File: sv/ssag_gain_engine.sv
// Sequenced gain engine: sines by polynomial and the gain products on one multiplier.
`default_nettype none
module ssag_gain_engine #(
  parameter int ANGLE_WIDTH        = 16,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [ANGLE_WIDTH-1:0] cfg_data_i,
  output      logic                   busy_o,
  output      logic signed [GAIN_FRACTION_BITS+1:0] gains_o [ssag_pkg::N_CH]
);
  import ssag_pkg::*;

  localparam int AW = ANGLE_WIDTH;
  localparam int GF = GAIN_FRACTION_BITS;
  localparam int GW = GF + 2;
  localparam int GS = QBITS - GF;

  eng_state_e state_q, state_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [AW-1:0] angle_x_q, angle_y_q;
  logic sign_q, sign_d;
  logic signed [QW-1:0] rf [RF_DEPTH];
  logic signed [QW-1:0] rd_a_q, rd_b_q;
  logic [2*QW-3:0] prod_q;
  logic neg_q;
  logic signed [GW-1:0] gains_q [N_CH];
  op_t op;

  logic [AW-1:0] qt_c, et_c, phase;
  logic [AW-2:0] r, rr;
  logic [QW-1:0] t_val;
  logic          rf_we;
  logic [RF_AW-1:0] rf_wa;
  logic signed [QW-1:0] rf_wd;
  logic          gain_we;
  logic signed [GW-1:0] gain_wd;
  logic signed [QW-1:0] op_b;
  logic [QW-2:0] ma, mb;
  logic [2*QW-1:0] rsum;
  logic [QW-1:0] m, mc;
  logic [QW-1:0] gsum;
  logic [GW-1:0] gmag;

  assign op     = prog(pc_q);
  assign busy_o = (state_q != ENG_IDLE);

  // Phase of the sine being loaded, reduced to a quarter wave.
  assign qt_c = AW'(1) << (AW - 2);
  assign et_c = AW'(1) << (AW - 3);
  always_comb begin
    case (op.ra[2:0])
      PH_SX:   phase = angle_x_q;
      PH_CX:   phase = angle_x_q + qt_c;
      PH_SY:   phase = angle_y_q;
      PH_CY:   phase = angle_y_q + qt_c;
      PH_A:    phase = angle_x_q + et_c;
      PH_B:    phase = angle_y_q + et_c + et_c + et_c + qt_c;
      PH_C:    phase = angle_y_q - (et_c + et_c + et_c);
      default: phase = angle_x_q;
    endcase
  end
  assign r     = {1'b0, phase[AW-3:0]};
  assign rr    = phase[AW-2] ? ((AW-1)'(1) << (AW - 2)) - r : r;
  assign t_val = QW'(rr) << (32 - AW);

  // Multiplier works on magnitudes; the sign is put back after rounding.
  assign op_b = op.b_const ? $signed(poly(3'd5)) : rd_b_q;
  assign ma   = rd_a_q[QW-1] ? (QW-1)'(-rd_a_q) : (QW-1)'(rd_a_q);
  assign mb   = op_b[QW-1] ? (QW-1)'(-op_b) : (QW-1)'(op_b);
  assign rsum = (2*QW)'(prod_q) + ((2*QW)'(1) << (QBITS - 1));
  assign m    = rsum[QBITS+QW-1:QBITS];
  assign mc   = (m > Q_ONE) ? Q_ONE : m;
  assign gsum = m + (QW'(1) << (GS - 1));
  assign gmag = GW'(gsum >> GS);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    sign_d  = sign_q;
    rf_we   = 1'b0;
    rf_wa   = op.dst;
    rf_wd   = '0;
    gain_we = 1'b0;
    gain_wd = neg_q ? -$signed(gmag) : $signed(gmag);
    case (state_q)
      ENG_IDLE: ;
      ENG_RD: begin
        if (op.kind == OP_LOADT) begin
          rf_we  = 1'b1;
          rf_wd  = $signed(t_val);
          sign_d = phase[AW-1];
          pc_d   = pc_q + 1'b1;
        end else begin
          state_d = ENG_MUL;
        end
      end
      ENG_MUL: state_d = ENG_WB;
      ENG_WB: begin
        case (op.kind)
          OP_SUBK:  begin rf_we = 1'b1; rf_wd = $signed(poly(op.k) - m); end
          OP_FINAL: begin rf_we = 1'b1; rf_wd = sign_q ? -$signed(mc) : $signed(mc); end
          OP_GAIN:  gain_we = 1'b1;
          default:  begin rf_we = 1'b1; rf_wd = neg_q ? -$signed(m) : $signed(m); end
        endcase
        if (pc_q == PC_W'(PROG_LEN - 1)) begin
          state_d = ENG_IDLE;
        end else begin
          state_d = ENG_RD;
          pc_d    = pc_q + 1'b1;
        end
      end
      default: state_d = ENG_IDLE;
    endcase
    // An angle write restarts the program.
    if (cfg_we_i) begin
      state_d = ENG_RD;
      pc_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ENG_RD;
      pc_q      <= '0;
      sign_q    <= 1'b0;
      angle_x_q <= '0;
      angle_y_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      sign_q  <= sign_d;
      if (cfg_we_i && cfg_idx_i == REG_ANGLE_X) angle_x_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == REG_ANGLE_Y) angle_y_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (state_q == ENG_RD) begin
      rd_a_q <= rf[op.ra];
      rd_b_q <= rf[op.rb];
    end
    if (state_q == ENG_MUL) begin
      prod_q <= ma * mb;
      neg_q  <= rd_a_q[QW-1] ^ op_b[QW-1];
    end
    if (gain_we) gains_q[op.dst[2:0]] <= gain_wd;
  end

  assign gains_o = gains_q;

endmodule
`default_nettype wire

// File: sv/ssag_lane.sv
// One channel lane: sample times gain, rounded and saturated over two stages.
`default_nettype none
module ssag_lane #(
  parameter int SAMPLE_WIDTH       = 24,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  load1_i,
  input  wire logic                                  load2_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  wire logic signed [GAIN_FRACTION_BITS+1:0]  gain_i,
  output      logic signed [SAMPLE_WIDTH-1:0]        result_o
);
  localparam int SW = SAMPLE_WIDTH;
  localparam int GF = GAIN_FRACTION_BITS;
  localparam int PW = SW + GF + 2;
  localparam int MW = PW - GF + 1;

  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] result_q, result_d;
  logic                 neg;
  logic [PW-1:0]        mag;
  logic [PW:0]          rsum;
  logic [MW-1:0]        m;

  assign neg  = prod_q[PW-1];
  assign mag  = neg ? PW'(-prod_q) : PW'(prod_q);
  assign rsum = (PW+1)'(mag) + ((PW+1)'(1) << (GF - 1));
  assign m    = MW'(rsum >> GF);

  always_comb begin
    if (!neg) begin
      if (m > (MW'(1) << (SW - 1)) - 1'b1) result_d = {1'b0, {(SW-1){1'b1}}};
      else result_d = SW'(m);
    end else begin
      if (m > (MW'(1) << (SW - 1))) result_d = {1'b1, {(SW-1){1'b0}}};
      else result_d = SW'(-$signed(m));
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1_i) prod_q <= PW'(sample_i) * PW'(gain_i);
    if (load2_i) result_q <= result_d;
  end

  assign result_o = result_q;

endmodule
`default_nettype wire

// File: sv/six_speaker_angle_gain_top.sv
// Six-speaker angle panner: six gain lanes fed by a sequenced gain engine.
// Each accepted item passes the lane product register and then the output register;
// one item per cycle is sustained while the output is taken and the engine is idle.
// After reset and after each angle write the gain engine runs its program (seven sines
// on its single multiplier, then 21 products); the input is not ready while it runs.
// Reset clears the handshake state.
`default_nettype none
module six_speaker_angle_gain_top #(
  parameter int SAMPLE_WIDTH       = 24,
  parameter int ANGLE_WIDTH        = 16,
  parameter int GAIN_FRACTION_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [ANGLE_WIDTH-1:0] cfg_data_i,
  ssag_in_if.sink                     in_chan,
  ssag_out_if.source                  out_chan
);
  import ssag_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int GW = GAIN_FRACTION_BITS + 2;

  logic busy;
  logic signed [GW-1:0] gains [N_CH];
  logic signed [SW-1:0] samples [N_CH];
  logic signed [SW-1:0] results [N_CH];
  logic v1_q, vo_q, move, ready1, acc;

  ssag_gain_engine #(
    .ANGLE_WIDTH        (ANGLE_WIDTH),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .gains_o    (gains)
  );

  // The output register drains when empty or taken; the product stage may fill behind it.
  assign move          = !vo_q || out_chan.ready;
  assign ready1        = !v1_q || move;
  assign in_chan.ready = ready1 && !busy && !cfg_we_i;
  assign acc           = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= acc;
      if (move) vo_q <= v1_q;
    end
  end

  assign samples[0] = in_chan.in_ch3;
  assign samples[1] = in_chan.in_ch4;
  assign samples[2] = in_chan.in_ch5;
  assign samples[3] = in_chan.in_ch6;
  assign samples[4] = in_chan.in_ch7;
  assign samples[5] = in_chan.in_ch8;

  for (genvar i = 0; i < N_CH; i++) begin : g_lane
    ssag_lane #(
      .SAMPLE_WIDTH       (SAMPLE_WIDTH),
      .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .load1_i  (acc),
      .load2_i  (move),
      .sample_i (samples[i]),
      .gain_i   (gains[i]),
      .result_o (results[i])
    );
  end

  assign out_chan.valid   = vo_q;
  assign out_chan.out_ch3 = results[0];
  assign out_chan.out_ch4 = results[1];
  assign out_chan.out_ch5 = results[2];
  assign out_chan.out_ch6 = results[3];
  assign out_chan.out_ch7 = results[4];
  assign out_chan.out_ch8 = results[5];

endmodule
`default_nettype wire

// File: verif/tb_six_speaker_angle_gain_top.sv
// Testbench for the six-speaker angle panner: predicted gains and scaled samples.
`timescale 1ns / 1ps
module tb_six_speaker_angle_gain_top;
  import ssag_pkg::*;

  localparam int SW = 24;
  localparam int AW = 16;
  localparam int GF = 16;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic signed [SW-1:0] c3, c4, c5, c6, c7, c8;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [AW-1:0] cfg_data_i = '0;

  ssag_in_if #(.W(SW)) in_chan ();
  ssag_out_if #(.W(SW)) out_chan ();

  six_speaker_angle_gain_top u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  frame_t scaled_frames[$];
  logic [AW-1:0] pan_x, pan_y;
  longint gain_q[6];
  int errors = 0;
  longint cycles = 0;
  int idle_pct = 16;
  int hold_cycles = 0;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.in_ch3 = '0; in_chan.in_ch4 = '0; in_chan.in_ch5 = '0;
    in_chan.in_ch6 = '0; in_chan.in_ch7 = '0; in_chan.in_ch8 = '0;
    out_chan.ready = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Fixed-point helpers for the gain prediction; all products are Q30.
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    bit neg;
    longint m;
    neg = (a < 0) != (b < 0);
    m = rnd_shift((a < 0 ? -a : a) * (b < 0 ? -b : b), 30);
    return neg ? -m : m;
  endfunction

  function automatic longint turn_sine(logic [AW-1:0] ph);
    longint coef[6];
    logic [1:0] q;
    longint r, t, t2, acc;
    coef = '{1686629713, 693598668, 85569306, 5026994, 172272, 3864};
    q = ph[AW-1:AW-2];
    r = ph[AW-3:0];
    if (q[0]) r = (longint'(1) << (AW - 2)) - r;
    t = r << (32 - AW);
    t2 = rnd_shift(t * t, 30);
    acc = coef[5];
    for (int k = 4; k >= 0; k--) acc = coef[k] - rnd_shift(t2 * acc, 30);
    acc = rnd_shift(t * acc, 30);
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    return q[1] ? -acc : acc;
  endfunction

  function automatic longint tenth_power(longint v);
    longint v2, v4, v8;
    v2 = q_mul(v, v);
    v4 = q_mul(v2, v2);
    v8 = q_mul(v4, v4);
    return q_mul(v8, v2);
  endfunction

  function automatic longint gain_round(longint g);
    longint m;
    m = rnd_shift(g < 0 ? -g : g, 30 - GF);
    return g < 0 ? -m : m;
  endfunction

  task automatic update_gains();
    logic [AW-1:0] qt, et;
    longint sx, cx, sy, cy, sx2, cx2, sy2, a, b, c;
    qt = AW'(1) << (AW - 2);
    et = AW'(1) << (AW - 3);
    sx = turn_sine(pan_x);
    cx = turn_sine(pan_x + qt);
    sy = turn_sine(pan_y);
    cy = turn_sine(pan_y + qt);
    sx2 = q_mul(sx, sx);
    cx2 = q_mul(cx, cx);
    sy2 = q_mul(sy, sy);
    a = tenth_power(turn_sine(pan_x + et));
    b = tenth_power(turn_sine(pan_y + et + et + et + qt));
    c = tenth_power(turn_sine(pan_y - (et + et + et)));
    gain_q[0] = gain_round(q_mul(sx2, sy2));
    gain_q[1] = gain_round(q_mul(cx2, sy2));
    gain_q[2] = gain_round(q_mul(a, cy));
    gain_q[3] = gain_round(q_mul(a, sy));
    gain_q[4] = gain_round(q_mul(b, sx));
    gain_q[5] = gain_round(q_mul(c, cx));
  endtask

  function automatic logic signed [SW-1:0] scale_sample(logic signed [SW-1:0] s, longint g);
    longint p, m, v;
    p = longint'(s) * g;
    m = rnd_shift(p < 0 ? -p : p, GF);
    v = p < 0 ? -m : m;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[SW-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // The valid line stays high from one item to the next unless the sender idles.
  task automatic send_frame(frame_t f);
    frame_t e;
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid <= 1'b1;
    in_chan.in_ch3 <= f.c3; in_chan.in_ch4 <= f.c4; in_chan.in_ch5 <= f.c5;
    in_chan.in_ch6 <= f.c6; in_chan.in_ch7 <= f.c7; in_chan.in_ch8 <= f.c8;
    do @(posedge clk_i); while (!in_chan.ready);
    e.c3 = scale_sample(f.c3, gain_q[0]);
    e.c4 = scale_sample(f.c4, gain_q[1]);
    e.c5 = scale_sample(f.c5, gain_q[2]);
    e.c6 = scale_sample(f.c6, gain_q[3]);
    e.c7 = scale_sample(f.c7, gain_q[4]);
    e.c8 = scale_sample(f.c8, gain_q[5]);
    scaled_frames.push_back(e);
  endtask

  function automatic logic signed [SW-1:0] pick_sample(int mode);
    case (mode)
      0: return -24'sd8388608;
      1: return 24'sd8388607;
      2: return SW'($urandom_range(3) - 2);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int m;
    m = ($urandom_range(9) < 2) ? $urandom_range(2) : 3;
    f.c3 = pick_sample(m); f.c4 = pick_sample(m); f.c5 = pick_sample(m);
    f.c6 = pick_sample(m); f.c7 = pick_sample(m); f.c8 = pick_sample(m);
    return f;
  endfunction

  // Angle writes only once the block is drained; the task does not wait for the gain engine to finish.
  task automatic write_angle(logic idx, logic [AW-1:0] val);
    in_chan.valid <= 1'b0;
    wait (scaled_frames.size() == 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ANGLE_X) pan_x = val; else pan_y = val;
    update_gains();
  endtask

  task automatic test_directed();
    frame_t f;
    f = '{-24'sd8388608, 24'sd8388607, 24'sd0, -24'sd1, 24'sd1, 24'sd8388607};
    send_frame(f);
    f = '{24'sd8388607, -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd2, 24'sd3};
    send_frame(f);
    f = '{24'sd12345, -24'sd12345, 24'sd32768, -24'sd32768, 24'sd65535, -24'sd8388608};
    send_frame(f);
    f = '{-24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1};
    send_frame(f);
  endtask

  task automatic test_angle_sweep();
    logic [AW-1:0] angles[10];
    angles = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
               16'h6000, 16'hA000, 16'hE000, 16'h1234};
    for (int i = 0; i < 10; i++) begin
      write_angle(REG_ANGLE_X, angles[i]);
      write_angle(REG_ANGLE_Y, angles[9 - i]);
      test_directed();
    end
  endtask

  task automatic test_random();
    for (int p = 0; p < 12; p++) begin
      write_angle(p[0] ? REG_ANGLE_Y : REG_ANGLE_X, AW'($urandom));
      idle_pct = (p == 5) ? 0 : 16;
      for (int i = 0; i < 68; i++) send_frame(random_frame());
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_frame(random_frame());
  endtask

  // Output side: random stalls, and a long hold-off when asked for.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= rst_ni && ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    frame_t e;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      if (scaled_frames.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        e = scaled_frames.pop_front();
        if (out_chan.out_ch3 !== e.c3) report_mismatch("out_ch3", out_chan.out_ch3, e.c3);
        if (out_chan.out_ch4 !== e.c4) report_mismatch("out_ch4", out_chan.out_ch4, e.c4);
        if (out_chan.out_ch5 !== e.c5) report_mismatch("out_ch5", out_chan.out_ch5, e.c5);
        if (out_chan.out_ch6 !== e.c6) report_mismatch("out_ch6", out_chan.out_ch6, e.c6);
        if (out_chan.out_ch7 !== e.c7) report_mismatch("out_ch7", out_chan.out_ch7, e.c7);
        if (out_chan.out_ch8 !== e.c8) report_mismatch("out_ch8", out_chan.out_ch8, e.c8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pan_x = '0;
    pan_y = '0;
    update_gains();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_angle_sweep();
    test_backpressure();
    test_random();
    write_angle(REG_ANGLE_X, 16'hFFFF);
    write_angle(REG_ANGLE_Y, 16'h0000);
    test_directed();
    in_chan.valid <= 1'b0;
    wait (scaled_frames.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
